// ===== rtl/zigzag_delta_row_codec_assert.svh =====
// assertion macros for the zigzag delta row codec checker
// no dependencies; included by the checker module
`ifndef ZIGZAG_DELTA_ROW_CODEC_ASSERT_SVH
`define ZIGZAG_DELTA_ROW_CODEC_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define ZDR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("zdr assertion failed");

// condition in one cycle implies an outcome in the next
`define ZDR_ASSERT_NEXT(label, clk, rst_n, cond, outcome) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (outcome)) \
		else $error("zdr assertion failed");

`endif

// ===== rtl/zdr_pkg.sv =====
// shared types, constants and sign folding functions for the zigzag delta row codec
// no dependencies; imported by zdr_apb_regs, zigzag_delta_row_codec, zdr_checker and the testbench
`default_nettype none

package zdr_pkg;

	localparam int unsigned ELEM_W          = 32;
	localparam int unsigned APB_DATA_W      = 32;
	localparam int unsigned APB_ADDR_W      = 4;
	localparam int unsigned SIGN_BIT_WIDE   = 31;
	localparam int unsigned SIGN_BIT_NARROW = 15;

	// register index, taken from paddr word bits
	typedef enum logic [1:0] {
		REG_DECODE_MODE   = 2'd0,
		REG_ZIGZAG_ENABLE = 2'd1,
		REG_WIDE_ELEMENTS = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic decode_mode;
		logic zigzag_enable;
		logic wide_elements;
	} cfg_t;

	typedef logic [ELEM_W-1:0] elem_t;

	// element width mask
	function automatic elem_t width_mask(input logic wide);
		width_mask = wide ? {ELEM_W{1'b1}} : {{(ELEM_W-16){1'b0}}, 16'hFFFF};
	endfunction

	// sign into bit 0: 0,-1,1,-2 -> 0,1,2,3
	function automatic elem_t fold_sign(input elem_t v, input logic wide);
		logic s;
		s = wide ? v[SIGN_BIT_WIDE] : v[SIGN_BIT_NARROW];
		fold_sign = ({v[ELEM_W-2:0], 1'b0} ^ {ELEM_W{s}}) & width_mask(wide);
	endfunction

	// inverse of fold_sign
	function automatic elem_t unfold_sign(input elem_t v, input logic wide);
		unfold_sign = ({1'b0, v[ELEM_W-1:1]} ^ {ELEM_W{v[0]}}) & width_mask(wide);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/zdr_apb_regs.sv =====
// apb configuration registers of the zigzag delta row codec
// depends on zdr_pkg for the register index and config types
`default_nettype none

module zdr_apb_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [zdr_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [zdr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [zdr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output zdr_pkg::cfg_t                        cfg
);
	import zdr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// register writes, bit 0 only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_DECODE_MODE:   cfg_q.decode_mode   <= pwdata[0];
				REG_ZIGZAG_ENABLE: cfg_q.zigzag_enable <= pwdata[0];
				REG_WIDE_ELEMENTS: cfg_q.wide_elements <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DECODE_MODE:   prdata[0] = cfg_q.decode_mode;
			REG_ZIGZAG_ENABLE: prdata[0] = cfg_q.zigzag_enable;
			REG_WIDE_ELEMENTS: prdata[0] = cfg_q.wide_elements;
			default:           prdata    = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/zigzag_delta_row_codec.sv =====
// zigzag delta row codec: an accepted element is held in s1, then its result is registered
// in s2 and offered on the master side
// throughput one item per cycle while m_tready is high; s_tready follows m_tready through the two stages
// input register s1, delta/sum logic, result register s2
// arst_n clears valid bits, previous value and config registers to zero
// depends on zdr_pkg and zdr_apb_regs
`default_nettype none

module zigzag_delta_row_codec (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// slave side
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [31:0]                     s_tdata,  // [31:0] element_in
	input  wire logic                            s_tuser,  // [0] row_start
	// master side
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [31:0]                     m_tdata,  // [31:0] element_out
	output logic                                 m_tuser,  // [0] row_start_out
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [zdr_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [zdr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [zdr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready
);
	import zdr_pkg::*;

	cfg_t  cfg;

	logic  valid_s1;
	elem_t elem_s1;
	logic  start_s1;

	logic  valid_s2;
	elem_t elem_s2;
	logic  start_s2;

	elem_t prev_q;

	logic  adv_s2;
	logic  load_s1;
	logic  move_s1;

	elem_t mask;
	elem_t x;
	elem_t prev;
	elem_t diff;
	elem_t addend;
	elem_t result;
	elem_t next_prev;

	zdr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage flow control
	assign adv_s2   = !valid_s2 || m_tready;
	assign move_s1  = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;
	assign load_s1  = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			elem_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// delta encode or running sum decode
	always_comb begin
		mask   = width_mask(cfg.wide_elements);
		x      = elem_s1 & mask;
		prev   = prev_q & mask;
		diff   = (x - prev) & mask;
		addend = cfg.zigzag_enable ? unfold_sign(x, cfg.wide_elements) : x;
		if (start_s1) begin
			result    = x;
			next_prev = x;
		end else if (!cfg.decode_mode) begin
			result    = cfg.zigzag_enable ? fold_sign(diff, cfg.wide_elements) : diff;
			next_prev = x;
		end else begin
			result    = (prev + addend) & mask;
			next_prev = result;
		end
	end

	// previous raw value or running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (move_s1) begin
			prev_q <= next_prev;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			elem_s2  <= result;
			start_s2 <= start_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = elem_s2;
	assign m_tuser  = start_s2;

endmodule

`default_nettype wire

// ===== rtl/zdr_checker.sv =====
// port level checks for the zigzag delta row codec, bound to the top level
// depends on zdr_pkg and zigzag_delta_row_codec_assert.svh
`default_nettype none

`include "zigzag_delta_row_codec_assert.svh"

module zdr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,  // [31:0] element_out
	input wire logic        m_tuser,  // [0] row_start_out
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [3:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic        pready
);
	import zdr_pkg::*;

	logic wide_q;
	logic in_acc;

	assign in_acc = s_tvalid && s_tready;

	// shadow of the element width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
				paddr[3:2] == REG_WIDE_ELEMENTS) begin
			wide_q <= pwdata[0];
		end
	end

	// stalled output item holds
	`ZDR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// accepted item reaches the output when m_tready does not stall it
	`ZDR_ASSERT_NEXT(a_latency, clk, arst_n, in_acc ##1 m_tready, m_tvalid)

	// empty output stage never blocks the input
	`ZDR_ASSERT(a_ready_when_empty, clk, arst_n, !m_tvalid |-> s_tready)

	// narrow elements leave the upper half clear
	`ZDR_ASSERT(a_narrow_high_zero, clk, arst_n,
		m_tvalid && !wide_q |-> m_tdata[31:16] == 16'h0000)

endmodule

bind zigzag_delta_row_codec zdr_checker u_zdr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.pready   (pready)
);

`default_nettype wire

// ===== sim/zigzag_delta_row_codec_tb.sv =====
// self-checking testbench for zigzag_delta_row_codec: streams rows through all register settings
// and compares every coded element against an in-bench delta/zigzag predictor
// depends on zdr_pkg and the codec rtl
`timescale 1ns / 1ps

module zigzag_delta_row_codec_tb;
	import zdr_pkg::*;

	localparam int unsigned ITEM_TARGET = 1050;
	localparam int unsigned PRINT_LIMIT = 40;

	typedef struct packed {
		logic [31:0] element;
		logic        row_start;
	} coded_element_t;

	// predictor of the row codec plus the queue of codes still owed by the block
	class row_code_scoreboard;
		bit                decode_mode;
		bit                zigzag_enable;
		bit                wide_elements;
		logic [31:0]       previous_value;
		coded_element_t    expected_codes[$];
		int unsigned       accepted_count;
		int unsigned       result_count;
		int unsigned       rows_seen;
		int unsigned       error_count;

		function new();
			decode_mode    = 1'b0;
			zigzag_enable  = 1'b0;
			wide_elements  = 1'b0;
			previous_value = '0;
			accepted_count = 0;
			result_count   = 0;
			rows_seen      = 0;
			error_count    = 0;
		endfunction

		function logic [31:0] element_mask();
			return wide_elements ? 32'hFFFF_FFFF : 32'h0000_FFFF;
		endfunction

		// sign moved into bit 0
		function logic [31:0] fold_difference(logic [31:0] d);
			logic neg;
			neg = wide_elements ? d[31] : d[15];
			return ((d << 1) ^ {32{neg}}) & element_mask();
		endfunction

		function logic [31:0] unfold_difference(logic [31:0] z);
			return ((z >> 1) ^ {32{z[0]}}) & element_mask();
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_DECODE_MODE:   decode_mode   = value[0];
				REG_ZIGZAG_ENABLE: zigzag_enable = value[0];
				REG_WIDE_ELEMENTS: wide_elements = value[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_DECODE_MODE:   return {31'b0, decode_mode};
				REG_ZIGZAG_ENABLE: return {31'b0, zigzag_enable};
				REG_WIDE_ELEMENTS: return {31'b0, wide_elements};
				default:           return '0;
			endcase
		endfunction

		// an accepted input element: work out the code it must produce
		function void note_element(logic [31:0] element, logic row_start);
			logic [31:0] mask;
			logic [31:0] x;
			logic [31:0] prev;
			logic [31:0] diff;
			logic [31:0] code;
			mask = element_mask();
			x    = element & mask;
			prev = previous_value & mask;
			if (row_start) begin
				code           = x;
				previous_value = x;
				rows_seen++;
			end else if (!decode_mode) begin
				diff           = (x - prev) & mask;
				code           = zigzag_enable ? fold_difference(diff) : diff;
				previous_value = x;
			end else begin
				diff           = zigzag_enable ? unfold_difference(x) : x;
				code           = (prev + diff) & mask;
				previous_value = code;
			end
			expected_codes.push_back('{code, row_start});
			accepted_count++;
		endfunction

		function void report(string what, logic [31:0] exp_val, logic [31:0] act_val);
			error_count++;
			if (error_count <= PRINT_LIMIT)
				$display("%0t: %s expected %h actual %h", $time, what, exp_val, act_val);
		endfunction

		// an accepted output element against the oldest owed code
		function void check_result(logic [31:0] element, logic row_start);
			coded_element_t want;
			result_count++;
			if (expected_codes.size() == 0) begin
				report("unexpected element_out, none owed", '0, element);
				return;
			end
			want = expected_codes.pop_front();
			if (element !== want.element)
				report("element_out", want.element, element);
			if (row_start !== want.row_start)
				report("row_start_out", {31'b0, want.row_start}, {31'b0, row_start});
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata  = '0;  // [31:0] element_in
	logic                  s_tuser  = 1'b0; // [0] row_start
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;        // [31:0] element_out
	logic                  m_tuser;        // [0] row_start_out
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	row_code_scoreboard sb = new();

	bit          sender_active = 1'b0;
	int unsigned burst_left    = 0;
	int unsigned sent_count    = 0;
	int unsigned setting_count = 0;
	logic [31:0] last_element  = '0;
	int unsigned rx_pattern    = 0;
	int unsigned rx_left       = 0;

	zigzag_delta_row_codec u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver backpressure: switches between open, random, periodic and heavy stall patterns
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_pattern = $urandom_range(0, 3);
			rx_left    = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		case (rx_pattern)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 3) != 0);
			2:       m_tready <= ((rx_left % 7) < 3);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// output monitor: values are stable at the falling edge before the accepting edge
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	task automatic lower_valid();
		if (sender_active) begin
			s_tvalid      <= 1'b0;
			sender_active  = 1'b0;
		end
	endtask

	// one item on the slave side, then maybe a gap once the burst runs out
	task automatic send_element(input logic [31:0] element, input logic row_start);
		logic        taken;
		int unsigned gap;
		s_tvalid      <= 1'b1;
		s_tdata       <= element;
		s_tuser       <= row_start;
		sender_active  = 1'b1;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		sb.note_element(element, row_start);
		last_element = element;
		sent_count++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
			gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
			if (gap != 0) begin
				lower_valid();
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// stop sending until every owed code has come back, then let the pipeline settle
	task automatic wait_for_results(input int unsigned settle);
		lower_valid();
		while (sb.expected_codes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// apb write, then read back unless the index is the unused one; each transfer returns the bus to idle
	task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
		logic        ready_seen;
		logic [31:0] read_data;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			ready_seen = pready;
			@(posedge clk);
		end while (!ready_seen);
		sb.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (idx == REG_UNUSED)
			return;
		psel    <= 1'b1;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			ready_seen = pready;
			read_data  = prdata;
			@(posedge clk);
		end while (!ready_seen);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (read_data !== sb.reg_value(idx))
			sb.report("register readback", sb.reg_value(idx), read_data);
	endtask

	// idle the codec and load a new setting; upper data bits are junk the block must drop
	task automatic program_codec(input bit decode, input bit zigzag, input bit wide);
		wait_for_results(4);
		if ($urandom_range(0, 3) == 0)
			write_register(REG_UNUSED, $urandom());
		write_register(REG_DECODE_MODE, ($urandom() & ~32'h1) | {31'b0, decode});
		write_register(REG_ZIGZAG_ENABLE, ($urandom() & ~32'h1) | {31'b0, zigzag});
		write_register(REG_WIDE_ELEMENTS, ($urandom() & ~32'h1) | {31'b0, wide});
		setting_count++;
	endtask

	// element values: edges, small steps from the last raw value, small codes and plain noise
	function automatic logic [31:0] pick_element(input logic [31:0] prev);
		case ($urandom_range(0, 7))
			0: return prev + $urandom_range(0, 16) - 8;
			1: return ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 3);
			2: return $urandom_range(0, 15);
			3: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
			4: case ($urandom_range(0, 5))
				0:       return 32'h8000_0000;
				1:       return 32'h7FFF_FFFF;
				2:       return ($urandom() & 32'hFFFF_0000) | 32'h8000;
				3:       return ($urandom() & 32'hFFFF_0000) | 32'h7FFF;
				4:       return 32'hFFFF_FFFF;
				default: return 32'h0;
			endcase
			default: return $urandom();
		endcase
	endfunction

	// rows of random length; some phases pick up the row left over from the last setting
	task automatic stream_rows(input int unsigned count, input bit hold_midway);
		int unsigned row_left;
		int unsigned n;
		logic        first;
		row_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		for (n = 0; n < count; n++) begin
			if (hold_midway && n == count / 2)
				wait_for_results(0);
			first = (row_left == 0);
			if (first)
				row_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				                                         : $urandom_range(1, 10);
			row_left--;
			send_element(pick_element(last_element), first);
		end
	endtask

	// run timeout
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned phase;
		logic [2:0]  setting;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting (plain encode, 16 bit), coding against zero before any row start
		send_element(32'hFFFF_0005, 1'b0);
		send_element(32'h1234_0003, 1'b0);
		send_element(32'hABCD_FFFF, 1'b1);
		send_element(32'h0000_0000, 1'b0);
		send_element(32'h0000_8000, 1'b0);
		send_element(32'h0000_7FFF, 1'b0);
		// zigzag encode, 16 bit, same row continues; write to the unused index too
		wait_for_results(4);
		write_register(REG_UNUSED, 32'hFFFF_FFFF);
		write_register(REG_ZIGZAG_ENABLE, 32'h0000_0001);
		send_element(32'h0000_0000, 1'b0);
		send_element(32'hFFFF_FFFF, 1'b0);
		send_element(32'h0000_0001, 1'b0);
		// zigzag encode, 32 bit
		program_codec(1'b0, 1'b1, 1'b1);
		send_element(32'h8000_0000, 1'b1);
		send_element(32'h7FFF_FFFF, 1'b0);
		send_element(32'h0000_0000, 1'b0);
		send_element(32'hFFFF_FFFF, 1'b0);
		send_element(32'h8000_0000, 1'b0);
		// zigzag decode, back to 16 bit mid-row: running value is cut to 16 bits
		program_codec(1'b1, 1'b1, 1'b0);
		send_element(32'h0001_FFFF, 1'b0);
		send_element(32'h0000_FFFE, 1'b0);
		send_element(32'h0000_0001, 1'b0);
		send_element(32'h0000_0000, 1'b1);
		// plain decode, 32 bit, wrapping sums
		program_codec(1'b1, 1'b0, 1'b1);
		send_element(32'hFFFF_FFFF, 1'b0);
		send_element(32'h0000_0001, 1'b0);
		send_element(32'h8000_0000, 1'b1);
		send_element(32'h7FFF_FFFF, 1'b0);
		send_element(32'hFFFF_FFFF, 1'b0);

		// random phases: all eight settings first, then random ones
		phase = 0;
		while (sent_count < ITEM_TARGET) begin
			setting = (phase < 8) ? phase[2:0] : 3'($urandom_range(0, 7));
			program_codec(setting[2], setting[1], setting[0]);
			stream_rows($urandom_range(30, 110), phase == 3);
			phase++;
		end

		wait_for_results(8);
		$display("%0d elements in %0d rows sent, %0d results checked", sent_count, sb.rows_seen,
			sb.result_count);
		$display("%0d register settings covering encode/decode, zigzag and both widths",
			setting_count);
		if (sb.error_count == 0 && sb.expected_codes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/zdr_pkg.sv
rtl/zdr_apb_regs.sv
rtl/zigzag_delta_row_codec.sv
rtl/zdr_checker.sv
sim/zigzag_delta_row_codec_tb.sv
